// ===== rtl/hmg_pkg.sv =====
// shared types and constants of the heightmap mesh generator
package hmg_pkg;

    // grid limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WSZ_W      = COL_W + 1;
    localparam int HSZ_W      = ROW_W + 1;

    // field widths
    localparam int CFG_SIZE_W = 11;
    localparam int STEP_W     = 24;
    localparam int LEVEL_W    = 8;
    localparam int POS_XZ_W   = 34;
    localparam int POS_Y_W    = 32;
    localparam int WEIGHT_W   = 16;
    localparam int IDX_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int TDATA_W    = 176;
    localparam int CMP_W      = (CFG_SIZE_W > HSZ_W)
                                ? ((CFG_SIZE_W > WSZ_W) ? CFG_SIZE_W : WSZ_W)
                                : ((HSZ_W > WSZ_W) ? HSZ_W : WSZ_W);

    // register reset values
    localparam logic [CFG_SIZE_W-1:0] MAP_WIDTH_RST  = CFG_SIZE_W'(256);
    localparam logic [CFG_SIZE_W-1:0] MAP_HEIGHT_RST = CFG_SIZE_W'(256);
    localparam logic [STEP_W-1:0]     X_STEP_RST     = STEP_W'(65536);
    localparam logic [STEP_W-1:0]     Z_STEP_RST     = STEP_W'(65536);
    localparam logic [STEP_W-1:0]     LEVEL_STEP_RST = STEP_W'(257);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_WIDTH  = 3'd0,
        CFG_MAP_HEIGHT = 3'd1,
        CFG_X_STEP     = 3'd2,
        CFG_Z_STEP     = 3'd3,
        CFG_LEVEL_STEP = 3'd4
    } hmg_cfg_idx_t;

    // record kinds
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_INDEX  = 1'b1;

    // record slots within one sample: vertex, then six corners
    localparam logic [2:0] SLOT_VERTEX   = 3'd0;
    localparam logic [2:0] SLOT_TL       = 3'd1;
    localparam logic [2:0] SLOT_BL_A     = 3'd2;
    localparam logic [2:0] SLOT_TR_A     = 3'd3;
    localparam logic [2:0] SLOT_BR       = 3'd4;
    localparam logic [2:0] SLOT_TR_B     = 3'd5;
    localparam logic [2:0] SLOT_BL_B     = 3'd6;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [IDX_W-1:0] num;
    } hmg_grid_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        hmg_grid_t          grid;
        logic [WSZ_W-1:0]   width;
    } hmg_sample_t;

    typedef struct packed {
        logic [POS_XZ_W-1:0] pos_x;
        logic [POS_Y_W-1:0]  pos_y;
        logic [POS_XZ_W-1:0] pos_z;
        logic                tex_u;
        logic                tex_v;
        logic [WEIGHT_W-1:0] weight_low;
        logic [WEIGHT_W-1:0] weight_mid;
        logic [WEIGHT_W-1:0] weight_high;
        logic                quad;
        logic [IDX_W-1:0]    br;
        logic [IDX_W-1:0]    bl;
        logic [IDX_W-1:0]    tr;
        logic [IDX_W-1:0]    tl;
    } hmg_vertex_t;

    typedef struct packed {
        logic                kind;
        logic [POS_XZ_W-1:0] pos_x;
        logic [POS_Y_W-1:0]  pos_y;
        logic [POS_XZ_W-1:0] pos_z;
        logic                tex_u;
        logic                tex_v;
        logic [WEIGHT_W-1:0] weight_low;
        logic [WEIGHT_W-1:0] weight_mid;
        logic [WEIGHT_W-1:0] weight_high;
        logic [IDX_W-1:0]    vertex_index;
        logic                last;
    } hmg_record_t;

endpackage

// ===== rtl/hmg_grid_counter.sv =====
// column, row and vertex number tracking of the incoming sample stream
module hmg_grid_counter
    import hmg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  restart,
    input  logic                  advance,
    input  logic [CFG_SIZE_W-1:0] map_width,
    input  logic [CFG_SIZE_W-1:0] map_height,
    output hmg_grid_t             grid,
    output logic [WSZ_W-1:0]      eff_width
);

    hmg_grid_t        grid_reg, grid_next;
    logic [CMP_W-1:0] width_ext, height_ext, width_sat, height_sat;
    logic [HSZ_W-1:0] eff_height;
    logic [WSZ_W-1:0] col_inc;
    logic [HSZ_W-1:0] row_inc;

    // zero acts as one, oversize saturates
    always_comb begin
        width_ext  = CMP_W'(map_width);
        height_ext = CMP_W'(map_height);
        if (width_ext == '0) begin
            width_sat = CMP_W'(1);
        end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
            width_sat = CMP_W'(MAX_WIDTH);
        end else begin
            width_sat = width_ext;
        end
        if (height_ext == '0) begin
            height_sat = CMP_W'(1);
        end else if (height_ext > CMP_W'(MAX_HEIGHT)) begin
            height_sat = CMP_W'(MAX_HEIGHT);
        end else begin
            height_sat = height_ext;
        end
        eff_width  = width_sat[WSZ_W-1:0];
        eff_height = height_sat[HSZ_W-1:0];
    end

    always_comb begin
        grid_next = grid_reg;
        col_inc   = {1'b0, grid_reg.col} + WSZ_W'(1);
        row_inc   = {1'b0, grid_reg.row} + HSZ_W'(1);
        if (restart) begin
            grid_next = '0;
        end else if (advance) begin
            grid_next.num = grid_reg.num + IDX_W'(1);
            if (col_inc >= eff_width) begin
                grid_next.col = '0;
                if (row_inc >= eff_height) begin
                    grid_next.row = '0;
                    grid_next.num = '0;
                end else begin
                    grid_next.row = row_inc[ROW_W-1:0];
                end
            end else begin
                grid_next.col = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_reg <= '0;
        end else begin
            grid_reg <= grid_next;
        end
    end

    assign grid = grid_reg;

endmodule

// ===== rtl/hmg_vertex_calc.sv =====
// registered stage computing vertex position, blend weights and quad corners
module hmg_vertex_calc
    import hmg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  hmg_sample_t       in_sample,
    input  logic [STEP_W-1:0] x_step,
    input  logic [STEP_W-1:0] z_step,
    input  logic [STEP_W-1:0] level_step,
    output logic              out_valid,
    input  logic              out_ready,
    output hmg_vertex_t       out_vertex
);

    // floor(y / 255) for 16-bit y with adds only
    function automatic logic [8:0] div255(input logic [15:0] y);
        logic [16:0] t;
        t = 17'(y) + 17'(y[15:8]) + 17'd1;
        return t[16:8];
    endfunction

    // num * 32768 / 255 rounded, num up to 255
    function automatic logic [WEIGHT_W-1:0] ratio255(input logic [7:0] num);
        logic [15:0] y;
        y = {1'b0, num, 7'd0} + 16'd127;
        return {1'b0, num, 7'd0} + WEIGHT_W'(div255(y));
    endfunction

    // num * 32768 / 102 rounded, num up to 102
    function automatic logic [WEIGHT_W-1:0] ratio102(input logic [6:0] num);
        logic [11:0] y;
        logic [25:0] p;
        y = 12'(num) * 12'd26 + 12'd51;
        p = 26'(y) * 26'd10281;
        return WEIGHT_W'(16'(num) * 16'd321) + WEIGHT_W'(p[25:20]);
    endfunction

    logic        valid_reg;
    hmg_vertex_t vertex_reg, vertex_next;
    logic [8:0]  two_s;
    logic [7:0]  level_dist;
    logic        load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        two_s      = {in_sample.level, 1'b0};
        level_dist = in_sample.level[7] ? 8'(two_s - 9'd255) : 8'(9'd255 - two_s);

        vertex_next.pos_x = POS_XZ_W'(in_sample.grid.col) * POS_XZ_W'(x_step);
        vertex_next.pos_y = POS_Y_W'(in_sample.level) * POS_Y_W'(level_step);
        vertex_next.pos_z = POS_XZ_W'(in_sample.grid.row) * POS_XZ_W'(z_step);
        vertex_next.tex_u = in_sample.grid.col[0];
        vertex_next.tex_v = in_sample.grid.row[0];

        // low band below half height, high band above
        vertex_next.weight_low  = in_sample.level[7] ? '0 : ratio255(level_dist);
        vertex_next.weight_high = in_sample.level[7] ? ratio255(level_dist) : '0;
        vertex_next.weight_mid  = (level_dist < 8'd102)
                                  ? ratio102(7'(8'd102 - level_dist)) : '0;

        vertex_next.quad = (in_sample.grid.col != '0) && (in_sample.grid.row != '0);
        vertex_next.br   = in_sample.grid.num;
        vertex_next.bl   = in_sample.grid.num - IDX_W'(1);
        vertex_next.tr   = in_sample.grid.num - IDX_W'(in_sample.width);
        vertex_next.tl   = in_sample.grid.num - IDX_W'(in_sample.width) - IDX_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            vertex_reg <= vertex_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_vertex = vertex_reg;

endmodule

// ===== rtl/hmg_record_seq.sv =====
// emits the vertex record and, for a quad sample, the six corner index records into the output register
module hmg_record_seq
    import hmg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  hmg_vertex_t in_vertex,
    output logic        out_valid,
    input  logic        out_ready,
    output hmg_record_t out_record
);

    logic [2:0]  slot_reg, slot_next;
    logic        valid_reg, valid_next;
    hmg_record_t rec_reg, rec_next;
    logic        load;
    logic        final_slot;

    assign load = !valid_reg || out_ready;

    always_comb begin
        rec_next   = '0;
        rec_next.kind = (slot_reg == SLOT_VERTEX) ? KIND_VERTEX : KIND_INDEX;
        final_slot = 1'b0;
        case (slot_reg)
            SLOT_VERTEX: begin
                rec_next.pos_x        = in_vertex.pos_x;
                rec_next.pos_y        = in_vertex.pos_y;
                rec_next.pos_z        = in_vertex.pos_z;
                rec_next.tex_u        = in_vertex.tex_u;
                rec_next.tex_v        = in_vertex.tex_v;
                rec_next.weight_low   = in_vertex.weight_low;
                rec_next.weight_mid   = in_vertex.weight_mid;
                rec_next.weight_high  = in_vertex.weight_high;
                rec_next.vertex_index = in_vertex.br;
                final_slot            = !in_vertex.quad;
            end
            SLOT_TL:   rec_next.vertex_index = in_vertex.tl;
            SLOT_BL_A: rec_next.vertex_index = in_vertex.bl;
            SLOT_TR_A: rec_next.vertex_index = in_vertex.tr;
            SLOT_BR:   rec_next.vertex_index = in_vertex.br;
            SLOT_TR_B: rec_next.vertex_index = in_vertex.tr;
            SLOT_BL_B: begin
                rec_next.vertex_index = in_vertex.bl;
                final_slot            = 1'b1;
            end
            default:   final_slot = 1'b1;
        endcase
        rec_next.last = final_slot;

        in_ready   = load && in_valid && final_slot;
        valid_next = load ? in_valid : valid_reg;
        slot_next  = slot_reg;
        if (load && in_valid) begin
            slot_next = final_slot ? SLOT_VERTEX : slot_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            slot_reg  <= SLOT_VERTEX;
        end else begin
            valid_reg <= valid_next;
            slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && in_valid) begin
            rec_reg <= rec_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_record = rec_reg;

    // a sample in progress stays put until its last record is loaded
    a_slot_holds_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (slot_reg != SLOT_VERTEX) |-> in_valid)
        else $error("record slot advanced without a pending vertex");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= SLOT_BL_B)
        else $error("record slot out of range");

    // only a vertex record may close a sample without a quad
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_ready && slot_reg == SLOT_VERTEX) |-> !in_vertex.quad)
        else $error("quad sample released after its vertex record");

    a_release_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |=> (valid_reg && rec_reg.last))
        else $error("sample released without a last record in the output");

endmodule

// ===== rtl/heightmap_mesh_generator_unit.sv =====
// top level of the heightmap to grid mesh generator
//
// s_ channel: one heightmap sample per transaction, row-major order. every
// sample gives one vertex record on the m_ channel; a sample that closes a
// grid quad (column and row both nonzero) adds six index records in corner
// order tl, bl, tr, br, tr, bl. m_tuser tells vertex (0) from index (1)
// records and m_tlast marks the final record of each sample.
// cfg channel: register writes (0 map_width, 1 map_height, 2 x_step,
// 3 z_step, 4 level_step), always ready; size writes restart the frame.
// the vertex record passes the input, vertex and output registers in turn.
// throughput: one sample per cycle on the first row and first column while
// m_tready is high; elsewhere a sample's seven records pass the single record
// output register in turn. three registers sit in the path (input, vertex,
// output), so samples still enter until they fill while a record waits on m_tready.
// reset (aresetn low, synchronous): registers return to their defaults,
// counters clear to the frame start, all pipeline stages empty.
// a stalled receiver holds the output record and backs up into s_tready.
module heightmap_mesh_generator_unit
    import hmg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input samples
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] sample_level
    // mesh records
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v,
                                             // weight_low, weight_mid, weight_high,
                                             // vertex_index, zero pad
    output logic                  m_tuser,   // record_kind
    output logic                  m_tlast,   // last record of this sample
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [CFG_SIZE_W-1:0] map_width_reg, map_height_reg;
    logic [STEP_W-1:0]     x_step_reg, z_step_reg, level_step_reg;
    logic                  cfg_write;
    logic                  restart;

    // input stage
    logic                  a_valid_reg;
    hmg_sample_t           a_sample_reg;
    logic                  s_accept;

    hmg_grid_t             grid;
    logic [WSZ_W-1:0]      eff_width;
    logic                  calc_ready;
    logic                  vtx_valid, vtx_ready;
    hmg_vertex_t           vertex;
    hmg_record_t           record;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign restart   = cfg_write && ((cfg_index == CFG_MAP_WIDTH) ||
                                     (cfg_index == CFG_MAP_HEIGHT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg  <= MAP_WIDTH_RST;
            map_height_reg <= MAP_HEIGHT_RST;
            x_step_reg     <= X_STEP_RST;
            z_step_reg     <= Z_STEP_RST;
            level_step_reg <= LEVEL_STEP_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_MAP_WIDTH:  map_width_reg  <= cfg_data[CFG_SIZE_W-1:0];
                CFG_MAP_HEIGHT: map_height_reg <= cfg_data[CFG_SIZE_W-1:0];
                CFG_X_STEP:     x_step_reg     <= cfg_data[STEP_W-1:0];
                CFG_Z_STEP:     z_step_reg     <= cfg_data[STEP_W-1:0];
                CFG_LEVEL_STEP: level_step_reg <= cfg_data[STEP_W-1:0];
                default:        ; // unknown index, write dropped
            endcase
        end
    end

    // input register: sample tagged with its grid position
    assign s_tready = !a_valid_reg || calc_ready;
    assign s_accept = s_tvalid && s_tready;

    hmg_grid_counter u_grid (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .restart    (restart),
        .advance    (s_accept),
        .map_width  (map_width_reg),
        .map_height (map_height_reg),
        .grid       (grid),
        .eff_width  (eff_width)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_tready) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_sample_reg.level <= s_tdata;
            a_sample_reg.grid  <= grid;
            a_sample_reg.width <= eff_width;
        end
    end

    hmg_vertex_calc u_calc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (a_valid_reg),
        .in_ready   (calc_ready),
        .in_sample  (a_sample_reg),
        .x_step     (x_step_reg),
        .z_step     (z_step_reg),
        .level_step (level_step_reg),
        .out_valid  (vtx_valid),
        .out_ready  (vtx_ready),
        .out_vertex (vertex)
    );

    hmg_record_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (vtx_valid),
        .in_ready   (vtx_ready),
        .in_vertex  (vertex),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_record (record)
    );

    // pack the record, first field in the lowest bits
    assign m_tdata = {6'd0, record.vertex_index, record.weight_high, record.weight_mid,
                      record.weight_low, record.tex_v, record.tex_u, record.pos_z,
                      record.pos_y, record.pos_x};
    assign m_tuser = record.kind;
    assign m_tlast = record.last;

endmodule
